// ===== sv/ivmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Inter-VM mailbox package
// Shared constants, codes and types of the mailbox queues.
// ----------------------------------------------------------------------------
package ivmq_pkg;

   localparam int NumVmsDefault     = 8;
   localparam int QueueDepthDefault = 8;
   localparam int MsgBytesDefault   = 256;
   localparam int MaxResults        = 64;
   localparam int IdW               = 8;
   localparam int CallerW           = 3;
   localparam int SizeW             = 12;
   localparam int WordW             = 32;
   localparam int StatusW           = 3;
   localparam int ReqDataW          = 64;
   localparam int RspDataW          = 56;

   typedef enum logic [1:0] {
      FUNC_GET_ID = 2'd0,
      FUNC_QUERY  = 2'd1,
      FUNC_SEND   = 2'd2,
      FUNC_RECV   = 2'd3
   } func_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK        = 3'd0,
      ST_TOO_BIG   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_NOT_READY = 3'd3,
      ST_FULL      = 3'd4,
      ST_EMPTY     = 3'd5
   } status_type;

   localparam logic [0:0] CsrPresent  = 1'b0;
   localparam logic [0:0] CsrNotReady = 1'b1;

   typedef struct packed {
      func_type               func;
      logic [CallerW-1:0]     caller;
      logic [IdW-1:0]         target;
      logic [SizeW-1:0]       size;
      logic [WordW-1:0]       data;
      logic                   last;
   } cmd_type;

   typedef struct packed {
      status_type             status;
      logic [SizeW-1:0]       value;
      logic [CallerW-1:0]     sender;
      logic [WordW-1:0]       word;
      logic                   last;
      logic                   irq;
   } rsp_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LEN,
      BK_RECV,
      BK_WAIT
   } back_state_type;

endpackage

// ===== sv/inter_vm_mailbox_queues.sv =====
// ----------------------------------------------------------------------------
// Inter-VM mailbox queues
// One ring of message slots per virtual machine, with get-id, send, receive and query.
// ----------------------------------------------------------------------------
// Get-id, query and send requests are taken back to back through a two-entry
// request queue while the response output is not stalled; a send run writes
// one word per cycle into the message memory on the same condition. A receive
// is accepted in the idle state, which loads the message size and sender into
// registers; the length state works out the word count, and each message word
// then passes a read state on the registered memory port and a wait state.
module inter_vm_mailbox_queues
   import ivmq_pkg::*;
#(
   parameter int NUM_VMS     = NumVmsDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int MSG_BYTES   = MsgBytesDefault
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [0:0]          csr_index,
   input  logic [7:0]          csr_wdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // func, caller id, destination id, size in bytes, data word, zero fill
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // status, value, sender_id, rx_word, raise_irq, zero fill
   output logic [RspDataW-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   logic [7:0] present_ff, not_ready_ff;
   logic       cmd_valid, cmd_ready;
   cmd_type    cmd;
   rsp_type    rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff   <= '0;
         not_ready_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrPresent:  present_ff   <= csr_wdata;
            CsrNotReady: not_ready_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ivmq_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .cmd_valid, .cmd_ready, .cmd
   );

   ivmq_back #(
      .NUM_VMS(NUM_VMS), .QUEUE_DEPTH(QUEUE_DEPTH), .MSG_BYTES(MSG_BYTES)
   ) u_back (
      .clock, .reset, .present_mask(present_ff), .not_ready_mask(not_ready_ff),
      .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp
   );

   assign rsp_tdata = {5'd0, rsp.irq, rsp.word, rsp.sender, rsp.value, rsp.status};
   assign rsp_tlast = rsp.last;

endmodule

// ===== sv/ivmq_front.sv =====
// ----------------------------------------------------------------------------
// Inter-VM mailbox front end
// Accepts requests, unpacks them and holds them in a short queue.
// ----------------------------------------------------------------------------
module ivmq_front
   import ivmq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tlast,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cmd_type             cmd
);

   cmd_type    q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push, pop;
   cmd_type    c;

   always_comb begin
      c.func   = func_type'(req_tdata[1:0]);
      c.caller = req_tdata[4:2];
      c.target = req_tdata[12:5];
      c.size   = req_tdata[24:13];
      c.data   = req_tdata[56:25];
      c.last   = req_tlast;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
      end
      if (push) begin
         q_ff[wp_ff] <= c;
      end
   end

endmodule

// ===== sv/ivmq_back.sv =====
// ----------------------------------------------------------------------------
// Inter-VM mailbox back end
// Carries out commands against the queue state and message memory.
// ----------------------------------------------------------------------------
module ivmq_back
   import ivmq_pkg::*;
#(
   parameter int NUM_VMS     = NumVmsDefault,
   parameter int QUEUE_DEPTH = QueueDepthDefault,
   parameter int MSG_BYTES   = MsgBytesDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  present_mask,
   input  logic [7:0]  not_ready_mask,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp
);

   localparam int Wpm   = (MSG_BYTES + 3) / 4;
   localparam int VmW   = (NUM_VMS > 1) ? $clog2(NUM_VMS) : 1;
   localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int WW    = (Wpm > 1) ? $clog2(Wpm) : 1;
   localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int IdxW  = $clog2(Wpm + 1);
   localparam int NSl   = NUM_VMS * QUEUE_DEPTH;
   localparam int SlW   = $clog2(NSl);
   localparam int Lim   = (Wpm < MaxResults) ? Wpm : MaxResults;
   localparam int LimW  = $clog2(Lim + 1);

   logic [WordW-1:0]   words_mem [NSl * Wpm];
   logic [SizeW-1:0]   size_mem  [NSl];
   logic [CallerW-1:0] sndr_mem  [NSl];

   logic [QW-1:0]   head_ff [NUM_VMS];
   logic [QW-1:0]   tail_ff [NUM_VMS];
   logic [CntW-1:0] count_ff [NUM_VMS];
   logic [IdxW-1:0] idx_ff, idx_in;
   status_type      err_ff, err_in;

   back_state_type  st_ff, st_in;
   logic [SlW-1:0]  rslot_ff, rslot_in;
   logic [LimW-1:0] rk_ff, rk_in, rn_ff, rn_in;
   logic [SizeW-1:0]   rsz_ff;
   logic [CallerW-1:0] rsd_ff;
   logic               rsz_load;

   rsp_type out_ff, out_in;
   logic    ov_ff, ov_in;
   logic [WordW-1:0] rd_ff;

   logic         tgt_ok;
   logic [VmW-1:0] tgt, cal;
   logic         cal_ok;
   logic         tgt_nr;
   status_type   chk, err_eff;
   logic         take;
   logic         wr_en;
   logic [SlW-1:0] wslot;
   logic         commit, pop_q;
   logic         rd_en;
   logic [SizeW-1:0] nwords;
   logic [SizeW-1:0] nsz_raw;
   logic [SlW-1:0] hslot;
   logic         out_free;

   assign tgt    = cmd.target[VmW-1:0];
   assign cal    = VmW'(cmd.caller);
   assign tgt_ok = (32'(cmd.target) < NUM_VMS) && present_mask[cmd.target[2:0]]
                   && (cmd.target < 8'd8);
   assign tgt_nr = (cmd.target < 8'd8) && not_ready_mask[cmd.target[2:0]];
   assign cal_ok = 32'(cmd.caller) < NUM_VMS;
   assign wslot  = SlW'(32'(tgt) * QUEUE_DEPTH + 32'(tail_ff[tgt]));
   assign hslot  = SlW'(32'(cal) * QUEUE_DEPTH + 32'(head_ff[cal]));
   assign out_free = !ov_ff || rsp_ready;
   assign rsp_valid = ov_ff;

   always_comb begin
      rsp      = out_ff;
      rsp.word = (st_ff == BK_WAIT || out_ff.word[0]) ? rd_ff : '0;
      if (!out_ff.word[0]) begin
         rsp.word = '0;
      end
   end

   always_comb begin
      if (32'(cmd.size) > MSG_BYTES) begin
         chk = ST_TOO_BIG;
      end else if (!tgt_ok) begin
         chk = ST_NOT_FOUND;
      end else if (tgt_nr) begin
         chk = ST_NOT_READY;
      end else if (32'(count_ff[tgt]) >= QUEUE_DEPTH) begin
         chk = ST_FULL;
      end else begin
         chk = ST_OK;
      end
   end

   always_comb begin
      nsz_raw = SizeW'((32'(rsz_ff) + 32'd3) >> 2);
      nwords  = nsz_raw;
   end

   always_comb begin
      st_in    = st_ff;
      idx_in   = idx_ff;
      err_in   = err_ff;
      rslot_in = rslot_ff;
      rk_in    = rk_ff;
      rn_in    = rn_ff;
      out_in   = out_ff;
      ov_in    = ov_ff && !rsp_ready;
      take     = 1'b0;
      wr_en    = 1'b0;
      commit   = 1'b0;
      pop_q    = 1'b0;
      rd_en    = 1'b0;
      rsz_load = 1'b0;
      err_eff  = (err_ff == ST_OK) ? chk : err_ff;
      unique case (st_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               take = 1'b1;
               out_in = '0;
               out_in.last = 1'b1;
               unique case (cmd.func)
                  FUNC_GET_ID: begin
                     ov_in = 1'b1;
                     out_in.value = SizeW'(cmd.caller);
                  end
                  FUNC_QUERY: begin
                     ov_in = 1'b1;
                     if (!tgt_ok) begin
                        out_in.status = ST_NOT_FOUND;
                     end else if (tgt_nr) begin
                        out_in.status = ST_NOT_READY;
                     end else begin
                        out_in.value = SizeW'(1);
                     end
                  end
                  FUNC_SEND: begin
                     wr_en = (err_eff == ST_OK) && (32'(idx_ff) < Wpm);
                     idx_in = (32'(idx_ff) < Wpm) ? idx_ff + IdxW'(1) : idx_ff;
                     err_in = err_eff;
                     if (cmd.last) begin
                        idx_in = '0;
                        err_in = ST_OK;
                        ov_in  = 1'b1;
                        out_in.status = err_eff;
                        if (err_eff == ST_OK) begin
                           commit = 1'b1;
                           out_in.value = cmd.size;
                           out_in.irq = 1'b1;
                        end else begin
                           out_in.irq = (err_eff == ST_FULL);
                        end
                     end
                  end
                  default: begin
                     if (!cal_ok || count_ff[cal] == '0) begin
                        ov_in = 1'b1;
                        out_in.status = ST_EMPTY;
                     end else begin
                        pop_q    = 1'b1;
                        rsz_load = 1'b1;
                        rslot_in = hslot;
                        rk_in    = '0;
                        st_in    = BK_LEN;
                     end
                  end
               endcase
            end
         end
         BK_LEN: begin
            if (32'(nwords) == 0) begin
               ov_in = 1'b1;
               out_in = '0;
               out_in.last   = 1'b1;
               out_in.value  = rsz_ff;
               out_in.sender = rsd_ff;
               st_in = BK_IDLE;
            end else begin
               rn_in = (32'(nwords) > Lim) ? LimW'(Lim) : LimW'(nwords);
               st_in = BK_RECV;
            end
         end
         BK_RECV: begin
            if (out_free) begin
               rd_en = 1'b1;
               st_in = BK_WAIT;
            end
         end
         BK_WAIT: begin
            ov_in = 1'b1;
            out_in = '0;
            out_in.value   = rsz_ff;
            out_in.sender  = rsd_ff;
            out_in.word[0] = 1'b1;
            out_in.last    = (rk_ff + LimW'(1) == rn_ff);
            rk_in = rk_ff + LimW'(1);
            st_in = out_in.last ? BK_IDLE : BK_RECV;
         end
         default: st_in = BK_IDLE;
      endcase
   end

   assign cmd_ready = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= BK_IDLE;
         idx_ff <= '0;
         err_ff <= ST_OK;
         ov_ff  <= 1'b0;
         for (int i = 0; i < NUM_VMS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         err_ff <= err_in;
         ov_ff  <= ov_in;
         if (commit) begin
            tail_ff[tgt]  <= (32'(tail_ff[tgt]) == QUEUE_DEPTH - 1) ? '0
                             : tail_ff[tgt] + QW'(1);
            count_ff[tgt] <= count_ff[tgt] + CntW'(1);
         end
         if (pop_q) begin
            head_ff[cal]  <= (32'(head_ff[cal]) == QUEUE_DEPTH - 1) ? '0
                             : head_ff[cal] + QW'(1);
            count_ff[cal] <= count_ff[cal] - CntW'(1);
         end
      end
      out_ff   <= out_in;
      rslot_ff <= rslot_in;
      rk_ff    <= rk_in;
      rn_ff    <= rn_in;
      if (rsz_load) begin
         rsz_ff <= size_mem[hslot];
         rsd_ff <= sndr_mem[hslot];
      end
      if (commit) begin
         size_mem[wslot] <= cmd.size;
         sndr_mem[wslot] <= cmd.caller;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[32'(wslot) * Wpm + 32'(idx_ff[WW-1:0])] <= cmd.data;
      end
      if (rd_en) begin
         rd_ff <= words_mem[32'(rslot_ff) * Wpm + 32'(rk_ff)];
      end
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// Mailbox queues testbench
// Streams get-id, query, send and receive requests into the mailbox block
// under several register settings. A model of the queues, updated as the
// requests are generated, gives the expected responses. A monitor compares
// them in order with the response stream, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import ivmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NVM   = NumVmsDefault;
   localparam int DEPTH = QueueDepthDefault;
   localparam int WORDS = (MsgBytesDefault + 3) / 4;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [0:0]          csr_index = CsrPresent;
   logic [7:0]          csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                req_tlast = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;

   inter_vm_mailbox_queues dut (.*);

   typedef struct packed {
      logic [ReqDataW-1:0] data;
      logic                last;
   } beat_type;

   beat_type pending_beats[$];
   rsp_type  awaited_rsps[$];

   logic [7:0]  present_mask, not_ready_mask;
   logic [31:0] msg_word [NVM*DEPTH*WORDS];
   bit          word_written [NVM*DEPTH*WORDS];
   int          msg_size [NVM*DEPTH];
   int          msg_sender [NVM*DEPTH];
   int          q_head [NVM], q_tail [NVM], q_count [NVM];
   int          run_index, run_error;
   int          mismatches, cycle_no, total_items;

   initial forever #5 clock = ~clock;

   initial begin
      #5ms;
      $display("tb: FAIL");
      $finish;
   end

   function automatic bit idle_now();
      if (cycle_no > 3000 && cycle_no < 7000) return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   function automatic status_type send_status(int target, int size);
      if (size > MsgBytesDefault) return ST_TOO_BIG;
      if (target >= NVM || !present_mask[target]) return ST_NOT_FOUND;
      if (not_ready_mask[target]) return ST_NOT_READY;
      if (q_count[target] >= DEPTH) return ST_FULL;
      return ST_OK;
   endfunction

   function automatic void add_rsp(status_type st, int value, int sender,
                                   logic [31:0] word, bit last, bit irq);
      rsp_type r;
      r.status = st;
      r.value  = value[SizeW-1:0];
      r.sender = sender[CallerW-1:0];
      r.word   = word;
      r.last   = last;
      r.irq    = irq;
      awaited_rsps.push_back(r);
   endfunction

   // Packs one request as the port carries it and updates the queue model
   // from exactly the bits that reach the block.
   function automatic void issue(func_type f, int caller, int target, int size,
                                 logic [31:0] word, bit last);
      logic [63:0] full;
      beat_type    b;
      cmd_type     c;
      int          slot, n;
      status_type  st;
      full = {7'd0, word, size[SizeW-1:0], target[IdW-1:0], caller[CallerW-1:0], f};
      b.data = full[ReqDataW-1:0];
      b.last = last;
      pending_beats.push_back(b);
      total_items++;
      full = b.data;
      c.func   = func_type'(full[1:0]);
      c.caller = full[4:2];
      c.target = full[12:5];
      c.size   = full[24:13];
      c.data   = full[56:25];
      c.last   = last;
      case (c.func)
         FUNC_GET_ID: add_rsp(ST_OK, c.caller, 0, 0, 1, 0);
         FUNC_QUERY: begin
            if (c.target >= NVM || !present_mask[c.target])
               add_rsp(ST_NOT_FOUND, 0, 0, 0, 1, 0);
            else if (not_ready_mask[c.target]) add_rsp(ST_NOT_READY, 0, 0, 0, 1, 0);
            else add_rsp(ST_OK, 1, 0, 0, 1, 0);
         end
         FUNC_SEND: begin
            st = send_status(c.target, c.size);
            if (run_error == ST_OK && st != ST_OK) run_error = st;
            if (run_error == ST_OK && run_index < WORDS) begin
               slot = c.target * DEPTH + q_tail[c.target];
               msg_word[slot*WORDS + run_index] = c.data;
               word_written[slot*WORDS + run_index] = 1'b1;
            end
            if (run_index < WORDS) run_index++;
            if (c.last) begin
               if (run_error == ST_OK) begin
                  slot = c.target * DEPTH + q_tail[c.target];
                  msg_size[slot] = c.size;
                  msg_sender[slot] = c.caller;
                  q_tail[c.target] = (q_tail[c.target] + 1) % DEPTH;
                  q_count[c.target]++;
                  add_rsp(ST_OK, c.size, 0, 0, 1, 1);
               end else begin
                  add_rsp(status_type'(run_error), 0, 0, 0, 1, run_error == ST_FULL);
               end
               run_index = 0;
               run_error = ST_OK;
            end
         end
         default: begin
            if (q_count[c.caller] == 0) begin
               add_rsp(ST_EMPTY, 0, 0, 0, 1, 0);
            end else begin
               slot = c.caller * DEPTH + q_head[c.caller];
               n = (msg_size[slot] + 3) / 4;
               if (n > WORDS) n = WORDS;
               if (n > MaxResults) n = MaxResults;
               if (n == 0) add_rsp(ST_OK, msg_size[slot], msg_sender[slot], 0, 1, 0);
               for (int k = 0; k < n; k++)
                  add_rsp(ST_OK, msg_size[slot], msg_sender[slot],
                          msg_word[slot*WORDS + k], k == n - 1, 0);
               q_count[c.caller]--;
               q_head[c.caller] = (q_head[c.caller] + 1) % DEPTH;
            end
         end
      endcase
   endfunction

   // A receive that would read words never written is turned into a query.
   function automatic void receive(int caller);
      int slot, n;
      bit ok;
      ok = 1'b1;
      if (q_count[caller] > 0) begin
         slot = caller * DEPTH + q_head[caller];
         n = (msg_size[slot] + 3) / 4;
         if (n > WORDS) n = WORDS;
         for (int k = 0; k < n; k++)
            if (!word_written[slot*WORDS + k]) ok = 1'b0;
      end
      if (ok) issue(FUNC_RECV, caller, $urandom_range(255), $urandom_range(4095),
                    $urandom, $urandom_range(1));
      else issue(FUNC_QUERY, caller, caller, 0, 0, 1);
   endfunction

   // One send run; short runs and a changed first target are kept only where
   // the committed slot still ends up fully written.
   function automatic void send_run(int caller, int target, int size, int nwords,
                                    bit change_first);
      int need, slot, other;
      need = (size + 3) / 4;
      if (need > WORDS) need = WORDS;
      if (nwords < 1) nwords = 1;
      if (target < NVM) begin
         slot = target * DEPTH + q_tail[target];
         for (int k = nwords; k < need; k++)
            if (!word_written[slot*WORDS + k]) nwords = need;
         if (nwords < 1) nwords = 1;
         if (change_first && !word_written[slot*WORDS]) change_first = 1'b0;
      end else begin
         change_first = 1'b0;
      end
      if (nwords < 2) change_first = 1'b0;
      other = (target + 1) % NVM;
      for (int k = 0; k < nwords; k++)
         issue(FUNC_SEND, caller, (change_first && k == 0) ? other : target, size,
               $urandom, k == nwords - 1);
   endfunction

   task automatic drain();
      while (pending_beats.size() != 0 || req_tvalid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CsrPresent) present_mask = val;
      else not_ready_mask = val;
   endtask

   task automatic random_phase(int count);
      int pick, size, tgt, n;
      int stop;
      stop = total_items + count;
      while (total_items < stop) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            tgt = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(NVM-1);
            pick = $urandom_range(99);
            if (pick < 65) size = $urandom_range(64);
            else if (pick < 88) size = $urandom_range(256, 65);
            else if (pick < 94) size = MsgBytesDefault;
            else size = $urandom_range(4095, 257);
            n = (size + 3) / 4;
            if (n > WORDS) n = WORDS;
            pick = $urandom_range(99);
            if (pick < 5) n = n + $urandom_range(6, 1);
            else if (pick < 15) n = $urandom_range(n);
            if (size > MsgBytesDefault) n = $urandom_range(3, 1);
            send_run($urandom_range(NVM-1), tgt, size, n, $urandom_range(19) == 0);
         end else if (pick < 80) begin
            receive($urandom_range(NVM-1));
         end else if (pick < 90) begin
            issue(FUNC_GET_ID, $urandom_range(NVM-1), $urandom_range(255),
                  $urandom_range(4095), $urandom, $urandom_range(1));
         end else begin
            issue(FUNC_QUERY, $urandom_range(NVM-1),
                  $urandom_range(1) ? $urandom_range(255) : $urandom_range(NVM-1),
                  $urandom_range(4095), $urandom, $urandom_range(1));
         end
      end
   endtask

   initial begin
      present_mask = '0;
      not_ready_mask = '0;
      run_index = 0;
      run_error = ST_OK;
      for (int i = 0; i < NVM; i++) begin
         q_head[i] = 0;
         q_tail[i] = 0;
         q_count[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      random_phase(30);
      write_csr(CsrPresent, 8'hFF);
      write_csr(CsrNotReady, 8'h04);
      issue(FUNC_GET_ID, 0, 0, 0, 32'h0, 0);
      issue(FUNC_GET_ID, 7, 255, 4095, 32'hFFFF_FFFF, 1);
      issue(FUNC_QUERY, 1, 0, 0, 0, 1);
      issue(FUNC_QUERY, 1, 2, 0, 0, 1);
      issue(FUNC_QUERY, 1, 8, 0, 0, 1);
      issue(FUNC_QUERY, 1, 255, 0, 0, 1);
      send_run(3, 1, 0, 1, 0);
      send_run(4, 1, 8, 2, 0);
      issue(FUNC_SEND, 2, 1, 4095, 32'h1234_5678, 1);
      send_run(2, 2, 4, 2, 0);
      for (int i = 0; i < DEPTH + 1; i++) send_run(6, 5, 4, 1, 0);
      receive(1);
      receive(1);
      receive(5);
      receive(6);
      drain();
      random_phase(80);
      write_csr(CsrPresent, 8'hA5);
      write_csr(CsrNotReady, 8'h0C);
      random_phase(70);
      write_csr(CsrPresent, 8'hFF);
      write_csr(CsrNotReady, 8'h00);
      random_phase(60);
      drain();
      random_phase(60);
      write_csr(CsrNotReady, 8'hFF);
      random_phase(30);
      write_csr(CsrPresent, 8'h7F);
      write_csr(CsrNotReady, 8'h80);
      random_phase(60);
      drain();
      if (mismatches == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && !idle_now()) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_beats[0].data;
               req_tlast  <= pending_beats[0].last;
               pending_beats.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !idle_now();
      end
   end

   always @(posedge clock) begin
      rsp_type     want;
      logic [63:0] wv;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected response data %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            want = awaited_rsps.pop_front();
            wv = {13'd0, want.irq, want.word, want.sender, want.value, want.status};
            if (wv[RspDataW-1:0] !== rsp_tdata || want.last !== rsp_tlast) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: response mismatch status %0d/%0d value %0d/%0d %s %0d/%0d %s %h/%h last %b/%b irq %b/%b",
                           want.status, rsp_tdata[2:0], want.value, rsp_tdata[14:3],
                           "sender", want.sender, rsp_tdata[17:15], "word",
                           wv[49:18], rsp_tdata[49:18], want.last, rsp_tlast,
                           want.irq, rsp_tdata[50]);
            end
         end
      end
   end

   initial begin
      cycle_no = 0;
      mismatches = 0;
      total_items = 0;
   end

endmodule

// ===== inter_vm_mailbox_queues.f =====
sv/ivmq_pkg.sv
sv/ivmq_front.sv
sv/ivmq_back.sv
sv/inter_vm_mailbox_queues.sv
verif/tb.sv
